>>> hdl/bfpu_pkg.sv
package bfpu_pkg;

    // Store geometry and field limits
    localparam int STORE_BYTES    = 256;
    localparam int MAX_FIELD_BITS = 32;

    // Fixed port field widths
    localparam int ValueW = 32;
    localparam int WidthW = 6;
    localparam int IndexW = 8;
    localparam int FreeW  = 4;

    // Derived widths
    localparam int AddrW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int IdxW   = AddrW + 1;                         // cursor may sit at STORE_BYTES
    localparam int RemW   = $clog2(STORE_BYTES * 8 + 1);       // bits left in store
    localparam int LeftW  = $clog2(MAX_FIELD_BITS + 1);        // bits left in field
    localparam int FieldW = MAX_FIELD_BITS;

    localparam logic [0:0] ACT_PACK   = 1'b0;
    localparam logic [0:0] ACT_UNPACK = 1'b1;

    // Byte store access from the sequencer
    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [7:0]       wdata;
        logic [AddrW-1:0] raddr;
    } t_mem_req;

endpackage

>>> hdl/bfpu_in_if.sv
interface bfpu_in_if import bfpu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [ValueW-1:0] field_value;
    logic [WidthW-1:0] field_width;

    modport source (output valid, output action, output field_value, output field_width,
                    input ready);
    modport sink   (input valid, input action, input field_value, input field_width,
                    output ready);
endinterface

>>> hdl/bfpu_out_if.sv
interface bfpu_out_if import bfpu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] read_value;
    logic [IndexW-1:0] byte_index;
    logic [FreeW-1:0]  bits_free;
    logic              overrun;

    modport source (output valid, output read_value, output byte_index, output bits_free,
                    output overrun, input ready);
    modport sink   (input valid, input read_value, input byte_index, input bits_free,
                    input overrun, output ready);
endinterface

>>> hdl/bit_field_packer_unpacker_top.sv
// MSB-first bit field packer/unpacker over a 256-byte store. Each input item either
// packs (ORs) a field of 0..32 bits at the write cursor or unpacks one at the
// independent read cursor; every item returns exactly one result holding the
// extracted value (zero on pack), the used cursor after the access, and an overrun
// flag set when the field would run past the end of the store, in which case
// nothing is touched. After reset the store zero-fills itself, and no item is accepted
// until it is done. Items are handled one at a time: each is checked for overrun, then
// its store bytes are read, and on pack written back, through the byte-wide store
// ports, pipelined one byte a cycle; a zero-width or overrun access goes straight to
// the result. A finished result sits in the output register while the next item is
// taken in.
module bit_field_packer_unpacker_top import bfpu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfpu_in_if.sink    i_in,
    bfpu_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // wait for an item
        S_CHK  = 4'b0010,   // overrun check, first byte read issued
        S_XFER = 4'b0100,   // one store byte per cycle
        S_HOLD = 4'b1000    // wait for output register
    } t_state;

    t_state r_state, n_state;

    // Persistent cursors
    logic [IdxW-1:0]  r_wr_idx, n_wr_idx;
    logic [3:0]       r_wr_bf, n_wr_bf;
    logic [IdxW-1:0]  r_rd_idx, n_rd_idx;
    logic [3:0]       r_rd_bf, n_rd_bf;

    // Working copy of the item
    logic             r_act, n_act;
    logic [FieldW-1:0] r_val, n_val;
    logic [LeftW-1:0] r_left, n_left;
    logic [IdxW-1:0]  r_idx, n_idx;
    logic [3:0]       r_bf, n_bf;
    logic [FieldW-1:0] r_acc, n_acc;
    logic             r_ovr, n_ovr;

    // Output register
    logic              r_o_valid, n_o_valid;
    logic [ValueW-1:0] r_o_value, n_o_value;
    logic [IndexW-1:0] r_o_index, n_o_index;
    logic [FreeW-1:0]  r_o_free, n_o_free;
    logic              r_o_ovr, n_o_ovr;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;

    logic             accept;
    logic             out_free;
    logic [7:0]       fw8;
    logic [LeftW-1:0] w_sat;
    logic [RemW-1:0]  rem;
    logic             ovr;
    logic [3:0]       take;
    logic [3:0]       sh;
    logic [7:0]       msk;
    logic [7:0]       chunk;
    logic [7:0]       rbits;
    logic [LeftW-1:0] left_nx;
    logic [3:0]       bf_nx;

    bfpu_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    assign i_in.ready = (r_state == S_IDLE) && !mem_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_o_valid || o_out.ready;

    // Width saturates to the field limit
    assign fw8   = 8'(i_in.field_width);
    assign w_sat = (fw8 > 8'(MAX_FIELD_BITS)) ? LeftW'(MAX_FIELD_BITS) : LeftW'(fw8);

    // Bits left between cursor and end of store
    always_comb begin
        if (r_idx < IdxW'(STORE_BYTES)) begin
            rem = (RemW'(IdxW'(STORE_BYTES) - r_idx) << 3) - RemW'(4'd8 - r_bf);
        end else begin
            rem = '0;
        end
    end
    assign ovr = RemW'(r_left) > rem;

    // Per-byte slice: bits taken from this byte and their position
    assign take    = (r_left < LeftW'(r_bf)) ? 4'(r_left) : r_bf;
    assign sh      = r_bf - take;
    assign msk     = 8'((9'd1 << take) - 9'd1);
    assign chunk   = 8'(r_val >> (r_left - LeftW'(take))) & msk;
    assign rbits   = (mem_rdata >> sh) & msk;
    assign left_nx = r_left - LeftW'(take);
    assign bf_nx   = r_bf - take;

    // Byte port: write back the current byte, read ahead the next one
    always_comb begin
        mem_req.we    = (r_state == S_XFER) && (r_act == ACT_PACK);
        mem_req.waddr = AddrW'(r_idx);
        mem_req.wdata = mem_rdata | 8'(chunk << sh);
        mem_req.raddr = (r_state == S_CHK) ? AddrW'(r_idx) : AddrW'(r_idx + IdxW'(1));
    end

    always_comb begin
        n_state   = r_state;
        n_wr_idx  = r_wr_idx;
        n_wr_bf   = r_wr_bf;
        n_rd_idx  = r_rd_idx;
        n_rd_bf   = r_rd_bf;
        n_act     = r_act;
        n_val     = r_val;
        n_left    = r_left;
        n_idx     = r_idx;
        n_bf      = r_bf;
        n_acc     = r_acc;
        n_ovr     = r_ovr;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_value = r_o_value;
        n_o_index = r_o_index;
        n_o_free  = r_o_free;
        n_o_ovr   = r_o_ovr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act   = i_in.action;
                    n_val   = FieldW'(i_in.field_value);
                    n_left  = w_sat;
                    n_idx   = (i_in.action == ACT_UNPACK) ? r_rd_idx : r_wr_idx;
                    n_bf    = (i_in.action == ACT_UNPACK) ? r_rd_bf : r_wr_bf;
                    n_acc   = '0;
                    n_ovr   = 1'b0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_left == '0) begin
                    n_state = S_HOLD;
                end else if (ovr) begin
                    n_ovr   = 1'b1;
                    n_state = S_HOLD;
                end else begin
                    n_state = S_XFER;
                end
            end
            S_XFER: begin
                n_acc  = (r_acc << take) | FieldW'(rbits);
                n_left = left_nx;
                if (bf_nx == 4'd0) begin
                    n_bf  = 4'd8;
                    n_idx = r_idx + IdxW'(1);
                end else begin
                    n_bf  = bf_nx;
                end
                if (left_nx == '0) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_value = (r_act == ACT_UNPACK) ? ValueW'(r_acc) : '0;
                    n_o_index = IndexW'(r_idx);
                    n_o_free  = FreeW'(r_bf);
                    n_o_ovr   = r_ovr;
                    if (r_act == ACT_UNPACK) begin
                        n_rd_idx = r_idx;
                        n_rd_bf  = r_bf;
                    end else begin
                        n_wr_idx = r_idx;
                        n_wr_bf  = r_bf;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_idx  <= '0;
            r_wr_bf   <= 4'd8;
            r_rd_idx  <= '0;
            r_rd_bf   <= 4'd8;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_idx  <= n_wr_idx;
            r_wr_bf   <= n_wr_bf;
            r_rd_idx  <= n_rd_idx;
            r_rd_bf   <= n_rd_bf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_val     <= n_val;
        r_left    <= n_left;
        r_idx     <= n_idx;
        r_bf      <= n_bf;
        r_acc     <= n_acc;
        r_ovr     <= n_ovr;
        r_o_value <= n_o_value;
        r_o_index <= n_o_index;
        r_o_free  <= n_o_free;
        r_o_ovr   <= n_o_ovr;
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.read_value = r_o_value;
    assign o_out.byte_index = r_o_index;
    assign o_out.bits_free  = r_o_free;
    assign o_out.overrun    = r_o_ovr;

endmodule

>>> hdl/bfpu_store.sv
// Byte store: one write and one registered read per cycle.
// Zero-fills itself after reset, one byte a cycle.
module bfpu_store import bfpu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata,
    output logic       o_busy
);

    logic [7:0]       r_mem [STORE_BYTES];
    logic [7:0]       r_rdata;
    logic [AddrW-1:0] r_clr_addr;
    logic [AddrW-1:0] n_clr_addr;
    logic             r_busy;
    logic             n_busy;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_busy     = r_busy;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + AddrW'(1);
            if (r_clr_addr == AddrW'(STORE_BYTES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign wr_en   = r_busy | i_req.we;
    assign wr_addr = r_busy ? r_clr_addr : i_req.waddr;
    assign wr_data = r_busy ? 8'h00 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

>>> tb/sv/bit_field_packer_unpacker_top_tb.sv
// Result of one item as the block reports it
typedef struct packed {
    logic [bfpu_pkg::ValueW-1:0] read_value;
    logic [bfpu_pkg::IndexW-1:0] byte_index;
    logic [bfpu_pkg::FreeW-1:0]  bits_free;
    logic                        overrun;
} field_result_t;

// Tracks the byte store and both cursors, predicts each result and checks it.
class packer_scoreboard;
    logic [7:0]    store_q [bfpu_pkg::STORE_BYTES];
    int unsigned   wr_index, wr_free;
    int unsigned   rd_index, rd_left;
    field_result_t pending_fields[$];
    int unsigned   errors, packs, unpacks, overruns, zero_widths, saturated, end_hits;

    function new();
        foreach (store_q[i]) store_q[i] = 8'h00;
        wr_index = 0;
        wr_free  = 8;
        rd_index = 0;
        rd_left  = 8;
    endfunction

    // Bits between a cursor and the end of the store
    function int unsigned room(logic act);
        int unsigned idx, nfree;
        idx   = (act == bfpu_pkg::ACT_UNPACK) ? rd_index : wr_index;
        nfree = (act == bfpu_pkg::ACT_UNPACK) ? rd_left : wr_free;
        if (idx >= bfpu_pkg::STORE_BYTES) return 0;
        return (bfpu_pkg::STORE_BYTES - idx) * 8 - (8 - nfree);
    endfunction

    function void apply_field(logic act, logic [bfpu_pkg::ValueW-1:0] val,
                              logic [bfpu_pkg::WidthW-1:0] wid);
        field_result_t               want;
        logic [bfpu_pkg::ValueW-1:0] acc;
        int unsigned                 n, idx, nfree, pos;
        bit                          unpack;
        unpack = (act == bfpu_pkg::ACT_UNPACK);
        want   = '0;
        acc    = '0;
        n      = (wid > bfpu_pkg::MAX_FIELD_BITS) ? bfpu_pkg::MAX_FIELD_BITS : wid;
        if (wid > bfpu_pkg::MAX_FIELD_BITS) saturated++;
        if (unpack) unpacks++; else packs++;
        if (n == 0) zero_widths++;
        if (n != 0 && n > room(act)) begin
            want.overrun = 1'b1;
            overruns++;
        end
        idx   = unpack ? rd_index : wr_index;
        nfree = unpack ? rd_left : wr_free;
        if (n != 0 && !want.overrun) begin
            // MSB first; only the low n bits of the value are ever looked at
            for (int i = n; i > 0; i--) begin
                pos = nfree - 1;
                if (unpack)
                    acc = {acc[bfpu_pkg::ValueW-2:0], store_q[idx][pos]};
                else
                    store_q[idx][pos] = store_q[idx][pos] | val[i-1];
                nfree--;
                if (nfree == 0) begin
                    nfree = 8;
                    idx++;
                end
            end
            if (idx == bfpu_pkg::STORE_BYTES) end_hits++;
        end
        if (unpack) begin
            rd_index = idx;
            rd_left  = nfree;
        end else begin
            wr_index = idx;
            wr_free  = nfree;
        end
        want.read_value = unpack ? acc : '0;
        want.byte_index = idx[bfpu_pkg::IndexW-1:0];
        want.bits_free  = nfree[bfpu_pkg::FreeW-1:0];
        pending_fields.push_back(want);
    endfunction

    function void check_field_result(field_result_t got);
        field_result_t want;
        if (pending_fields.size() == 0) begin
            $display("%0t: result with nothing pending: value %0h index %0d free %0d ovr %0b",
                     $realtime, got.read_value, got.byte_index, got.bits_free, got.overrun);
            errors++;
            return;
        end
        want = pending_fields.pop_front();
        if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0h, got %0h",
                     $realtime, want.read_value, got.read_value);
            errors++;
        end
        if (got.byte_index !== want.byte_index) begin
            $display("%0t: byte_index mismatch, expected %0d, got %0d",
                     $realtime, want.byte_index, got.byte_index);
            errors++;
        end
        if (got.bits_free !== want.bits_free) begin
            $display("%0t: bits_free mismatch, expected %0d, got %0d",
                     $realtime, want.bits_free, got.bits_free);
            errors++;
        end
        if (got.overrun !== want.overrun) begin
            $display("%0t: overrun mismatch, expected %0b, got %0b",
                     $realtime, want.overrun, got.overrun);
            errors++;
        end
    endfunction
endclass

module bit_field_packer_unpacker_top_tb;
    import bfpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_AT      = 250;     // items in before the long result stall
    localparam int HOLD_CYCLES  = 500;
    localparam int BURST_LO     = 700;     // random items sent back to back
    localparam int BURST_HI     = 850;
    localparam int TAIL_CYCLES  = 16;
    localparam int TIMEOUT_NS   = 1_500_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bfpu_in_if  in_if ();
    bfpu_out_if out_if ();

    bit_field_packer_unpacker_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    packer_scoreboard sb = new();
    int unsigned      items_sent = 0;
    bit               in_burst   = 1'b0;

    always #1 i_clk = ~i_clk;

    // Sender idle length: mostly none or short, now and then long
    function automatic int unsigned src_gap();
        int unsigned r;
        if (in_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ValueW-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return $urandom;
    endfunction

    // Offers one item after an optional idle stretch and returns once it is taken.
    // valid stays high across back-to-back items, so it gets one assignment per edge.
    task automatic send_field(logic act, logic [ValueW-1:0] val, logic [WidthW-1:0] wid);
        int unsigned gap;
        gap = src_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.field_value <= val;
        in_if.field_width <= wid;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.apply_field(act, val, wid);
        items_sent++;
    endtask

    // Result side: ready runs and stalls of random length, plus one long stall
    // while the sender keeps offering, so the block backs up into its input.
    initial begin : result_sink
        bit          held;
        int unsigned r;
        held = 1'b0;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && items_sent >= HOLD_AT) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                out_if.ready <= 1'b1;
                r = $urandom_range(0, 99);
                repeat (r < 85 ? $urandom_range(1, 16) : $urandom_range(40, 150))
                    @(posedge i_clk);
                out_if.ready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 60)      repeat (1) @(posedge i_clk);
                else if (r < 90) repeat ($urandom_range(2, 5)) @(posedge i_clk);
                else if (r < 98) repeat ($urandom_range(6, 20)) @(posedge i_clk);
                else             repeat ($urandom_range(30, 60)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_field_result('{out_if.read_value, out_if.byte_index,
                                    out_if.bits_free, out_if.overrun});
    end

    initial begin : timeout
        #(TIMEOUT_NS);
        $display("bit_field_packer_unpacker_top_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic        act;
        logic [WidthW-1:0] wid;
        int unsigned rem, per_item, hi, left, r;
        bit          tried;

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_PACK;
        in_if.field_value <= '0;
        in_if.field_width <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the store clears itself after reset; send_field just waits on ready

        // Directed: zero width on both cursors, width extremes, saturation,
        // masking of high value bits, and read-back of what was packed
        send_field(ACT_PACK,   32'hFFFF_FFFF, 6'd0);
        send_field(ACT_UNPACK, 32'hFFFF_FFFF, 6'd0);
        send_field(ACT_PACK,   32'h0000_0001, 6'd1);
        send_field(ACT_PACK,   32'hFFFF_FF55, 6'd7);
        send_field(ACT_PACK,   32'hFFFF_FFFF, 6'd32);
        send_field(ACT_PACK,   32'hA5A5_A5A5, 6'd33);
        send_field(ACT_PACK,   32'h1234_5678, 6'd63);
        send_field(ACT_PACK,   32'hFFFF_FFF8, 6'd3);
        send_field(ACT_PACK,   $urandom,      6'd13);
        send_field(ACT_UNPACK, $urandom,      6'd1);
        send_field(ACT_UNPACK, $urandom,      6'd7);
        send_field(ACT_UNPACK, $urandom,      6'd32);
        send_field(ACT_UNPACK, $urandom,      6'd40);
        send_field(ACT_UNPACK, $urandom,      6'd63);
        send_field(ACT_UNPACK, $urandom,      6'd3);
        send_field(ACT_UNPACK, $urandom,      6'd13);
        send_field(ACT_UNPACK, $urandom,      6'd16);   // past the write cursor: zeros
        send_field(ACT_PACK,   32'h0000_0000, 6'd32);
        send_field(ACT_PACK,   32'h0000_0080, 6'd8);
        send_field(ACT_PACK,   32'hDEAD_BEEF, 6'd24);
        send_field(ACT_UNPACK, 32'h0,         6'd8);
        send_field(ACT_UNPACK, 32'h0,         6'd24);

        // Random: widths scale with what is left of the store so both cursors
        // walk through the whole store over the run instead of hitting the end early
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            in_burst = (k >= BURST_LO && k < BURST_HI);
            act      = $urandom_range(0, 1) ? ACT_UNPACK : ACT_PACK;
            rem      = sb.room(act);
            left     = RANDOM_ITEMS - k;
            per_item = (rem * 2) / left;
            hi       = (2 * per_item < 1) ? 1 : ((2 * per_item > 32) ? 32 : 2 * per_item);
            r        = $urandom_range(0, 99);
            if (r < 6)
                wid = $urandom_range(0, 63);
            else if (r < 9 && rem >= 1 && rem <= 32)
                wid = rem;                            // land exactly on the end
            else if (r < 13)
                wid = 0;
            else
                wid = $urandom_range(1, hi);
            send_field(act, pick_value(), wid);
        end
        in_burst = 1'b0;

        // Run each cursor to the end of the store: one too-wide field while bits
        // still remain, an exact fit, then accesses from the end position
        for (int s = 0; s < 2; s++) begin
            act   = s ? ACT_UNPACK : ACT_PACK;
            tried = 1'b0;
            while (sb.room(act) > 0) begin
                rem = sb.room(act);
                if (rem > 32) begin
                    send_field(act, pick_value(), $urandom_range(24, 32));
                end else if (rem > 1 && !tried) begin
                    send_field(act, pick_value(), rem + 1);
                    tried = 1'b1;
                end else begin
                    send_field(act, pick_value(), rem);
                end
            end
            send_field(act, pick_value(), 6'd1);
            send_field(act, pick_value(), 6'd63);
            send_field(act, pick_value(), 6'd0);
        end
        in_if.valid <= 1'b0;

        while (sb.pending_fields.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d packs, %0d unpacks, %0d zero width, %0d over 32 bits",
                 items_sent, sb.packs, sb.unpacks, sb.zero_widths, sb.saturated);
        $display("%0d overruns, %0d fields ending on the last store bit, %0d errors",
                 sb.overruns, sb.end_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("bit_field_packer_unpacker_top_tb OK");
        end else begin
            $display("bit_field_packer_unpacker_top_tb NOT OK");
        end
        $finish;
    end
endmodule
